>>> hdl/grid_ray_cast_range_macros.svh
// Assertion helpers for the ray caster. Every use expects i_clk and i_rst_n in scope.
`ifndef GRID_RAY_CAST_RANGE_MACROS_SVH
`define GRID_RAY_CAST_RANGE_MACROS_SVH

// Overlapping implication, checked outside reset.
`define GRC_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked on the following clock edge, outside reset.
`define GRC_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/grc_pkg.sv
`timescale 1ns / 1ps

package grc_pkg;

    // Fixed point: map positions are Q10.FRAC_BITS, the walk runs in Q.WALK_FRAC.
    localparam int FRAC_BITS     = 8;
    localparam int WALK_FRAC     = FRAC_BITS + 16;
    localparam int MAP_CELLS_DEF = 65536;

    // Item field types.
    typedef logic               t_command;
    typedef logic [15:0]        t_cell_index;
    typedef logic signed [7:0]  t_cell_value;
    typedef logic [17:0]        t_pose;
    typedef logic [15:0]        t_heading;
    typedef logic [8:0]         t_beam;
    typedef logic [17:0]        t_dist;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_CAST  = 1'b1
    } t_cmd;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1,
        CFG_MAX_RANGE   = 2'd2
    } t_cfg_idx;

    // Slope divider: the dividend is a 32-bit magnitude shifted by WALK_FRAC.
    localparam int DIV_DEN_W = 32;
    localparam int DIV_NUM_W = DIV_DEN_W + WALK_FRAC;

    // Beam offset conversion to a 16-bit binary angle.
    localparam int DEG_TURN  = 360;
    localparam int DEG_ROUND = 180;

    // Reciprocal of a full turn in degrees: n / 360 equals (n * DEG_RECIP) >> DEG_RECIP_SH
    // for every dividend below 2^DEG_NUM_W.
    localparam int DEG_NUM_W    = 25;
    localparam int DEG_RECIP_W  = 26;
    localparam int DEG_RECIP_SH = 34;
    localparam logic [DEG_RECIP_W-1:0] DEG_RECIP = 26'd47721859;

    // CORDIC datapath.
    localparam int CORDIC_W     = 33;
    localparam int ANG_W        = 26;
    localparam int CORDIC_ITERS = 16;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [ANG_W-1:0]    QUARTER_24  = 26'sd4194304;
    localparam logic signed [ANG_W-1:0]    HALF_24     = 26'sd8388608;

    // Walk position width: sign, fifteen integer bits and WALK_FRAC fraction bits.
    localparam int POS_W = WALK_FRAC + 16;

    // Hit distance: rounded offsets and the square root over their squares.
    localparam int RND_SHIFT = WALK_FRAC - FRAC_BITS;
    localparam int SQ_IN_W   = 21;
    localparam int SQ_W      = 2 * SQ_IN_W + 4;

    // Arctangent of 2^-i in 2^24-per-turn units.
    function automatic logic signed [ANG_W-1:0] atan_lut(input logic [3:0] i);
        logic signed [ANG_W-1:0] a;
        case (i)
            4'd0:    a = 26'sd2097152;
            4'd1:    a = 26'sd1238021;
            4'd2:    a = 26'sd654136;
            4'd3:    a = 26'sd332050;
            4'd4:    a = 26'sd166669;
            4'd5:    a = 26'sd83416;
            4'd6:    a = 26'sd41718;
            4'd7:    a = 26'sd20860;
            4'd8:    a = 26'sd10430;
            4'd9:    a = 26'sd5215;
            4'd10:   a = 26'sd2608;
            4'd11:   a = 26'sd1304;
            4'd12:   a = 26'sd652;
            4'd13:   a = 26'sd326;
            4'd14:   a = 26'sd163;
            4'd15:   a = 26'sd81;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Arithmetic right shift that truncates toward zero.
    function automatic logic signed [CORDIC_W-1:0] shr_trunc(
        input logic signed [CORDIC_W-1:0] v,
        input logic [3:0] s
    );
        logic [CORDIC_W-1:0] mag;
        logic [CORDIC_W-1:0] sh;
        mag = v[CORDIC_W-1] ? $unsigned(-v) : $unsigned(v);
        sh  = mag >> s;
        return v[CORDIC_W-1] ? -$signed(sh) : $signed(sh);
    endfunction

    // Magnitude limited to 2^31.
    function automatic logic [DIV_DEN_W-1:0] mag_clamp(input logic signed [CORDIC_W-1:0] v);
        logic [CORDIC_W-1:0] mag;
        mag = v[CORDIC_W-1] ? $unsigned(-v) : $unsigned(v);
        if (mag > (CORDIC_W'(1) << 31)) begin
            mag = CORDIC_W'(1) << 31;
        end
        return mag[DIV_DEN_W-1:0];
    endfunction

endpackage

>>> hdl/grc_req_if.sv
`timescale 1ns / 1ps

// Request channel: map writes and ray queries.
interface grc_req_if;
    import grc_pkg::*;
    logic        valid;
    logic        ready;
    t_command    command;
    t_cell_index cell_index;
    t_cell_value cell_value;
    t_pose       pose_x;
    t_pose       pose_y;
    t_heading    heading;
    t_beam       beam_index;

    modport source (output valid, command, cell_index, cell_value, pose_x, pose_y,
                    heading, beam_index, input ready);
    modport sink   (input valid, command, cell_index, cell_value, pose_x, pose_y,
                    heading, beam_index, output ready);
endinterface

>>> hdl/grc_rsp_if.sv
`timescale 1ns / 1ps

// Response channel: one range item per ray query.
interface grc_rsp_if;
    import grc_pkg::*;
    logic  valid;
    logic  ready;
    t_dist distance;
    logic  hit;
    logic  left_map;

    modport source (output valid, distance, hit, left_map, input ready);
    modport sink   (input valid, distance, hit, left_map, output ready);
endinterface

>>> hdl/grc_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module grc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> hdl/grc_div.sv
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
module grc_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [grc_pkg::DIV_NUM_W-1:0]  i_dividend,
    input  logic [grc_pkg::DIV_DEN_W-1:0]  i_divisor,
    output logic                           o_done,
    output logic [grc_pkg::DIV_NUM_W-1:0]  o_quotient
);
    import grc_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0]   rem_sh;
    logic                 q_bit;
    logic [DIV_DEN_W:0]   rem_sub;

    // Shift in the next dividend bit and try to subtract the divisor.
    always_comb begin
        rem_sh  = {r_rem, r_num[DIV_NUM_W-1]};
        q_bit   = (rem_sh >= {1'b0, r_den});
        rem_sub = q_bit ? (rem_sh - {1'b0, r_den}) : rem_sh;
    end

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend register fills with quotient bits from the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NUM_W-2:0], q_bit};
            r_rem <= rem_sub[DIV_DEN_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_num;
endmodule

>>> hdl/grid_ray_cast_range.sv
`timescale 1ns / 1ps

// Occupancy map with a ray caster for expected laser ranges. A write item stores one
// obstacle bit (raw -1 and 0..89 are free, all else occupied); a write beyond
// MAP_CELLS is dropped. A query item casts one ray and yields one range item in Q10.8
// cells with hit and left_map flags; it runs through the beam offset, the CORDIC
// rotations, the slope division set-up and run, and an address, map read and test
// step per walked cell, then a final address step when the walk ends without a hit
// or the hit distance square root after a hit, one item at a time. After reset a
// clearing pass writes every map cell, one per cycle, so no item is accepted until
// the pass ends; configuration writes are taken at any time but must only change
// while the block is idle.
module grid_ray_cast_range #(
    parameter int MAP_CELLS = grc_pkg::MAP_CELLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [grc_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [grc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    grc_req_if.sink                        i_req,
    grc_rsp_if.source                      o_rsp
);
    import grc_pkg::*;

    localparam int AW         = $clog2(MAP_CELLS);
    localparam int IDX_W      = POS_W - 1 - WALK_FRAC;
    localparam int ROW_W      = IDX_W + CFG_DATA_W + 1;
    localparam int STEPS_W    = DIV_DEN_W + 10;
    localparam int SQ_A_W     = 2 * SQ_IN_W;
    localparam int DEG_PROD_W = DEG_NUM_W + DEG_RECIP_W;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_ANG   = 13'b0000000000010,
        S_COR   = 13'b0000000000100,
        S_PREP  = 13'b0000000001000,
        S_SLOPE = 13'b0000000010000,
        S_ADDR  = 13'b0000000100000,
        S_READ  = 13'b0000001000000,
        S_CHECK = 13'b0000010000000,
        S_RND   = 13'b0000100000000,
        S_SQ1   = 13'b0001000000000,
        S_SQ2   = 13'b0010000000000,
        S_SQRT  = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    // Configuration and control registers.
    logic [CFG_DATA_W-1:0] r_cfg_w, r_cfg_h;
    logic [9:0]            r_cfg_range;
    logic                  r_clr_busy;
    logic [AW-1:0]         r_clr_addr;
    logic                  r_out_valid;

    // Query datapath registers.
    t_pose                       r_x0, r_y0;
    t_heading                    r_heading;
    logic [8:0]                  r_tdeg;
    logic signed [CORDIC_W-1:0]  r_cx, r_cy;
    logic signed [ANG_W-1:0]     r_z;
    logic                        r_flip;
    logic [3:0]                  r_iter;
    logic                        r_xmaj, r_cneg, r_sneg;
    logic [11:0]                 r_left;
    logic signed [POS_W-1:0]     r_px, r_py, r_dx, r_dy;
    logic [AW-1:0]               r_addr;
    logic signed [POS_W-1:0]     r_ex, r_ey;
    logic [SQ_IN_W-1:0]          r_ax, r_ay;
    logic [SQ_W-1:0]             r_sum, r_sq_r, r_sq_bit;
    t_dist                       r_res_dist, r_out_dist;
    logic                        r_res_hit, r_res_left, r_out_hit, r_out_left;

    // Handshake.
    logic acc, acc_cast, acc_wr;
    assign i_req.ready = (r_state == S_IDLE) && !r_clr_busy;
    assign acc         = i_req.valid && i_req.ready;
    assign acc_cast    = acc && (i_req.command == CMD_CAST);
    assign acc_wr      = acc && (i_req.command == CMD_WRITE);

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= CFG_DATA_W'(256);
            r_cfg_h     <= CFG_DATA_W'(256);
            r_cfg_range <= 10'd200;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_GRID_WIDTH:  r_cfg_w     <= i_cfg_wdata;
                CFG_GRID_HEIGHT: r_cfg_h     <= i_cfg_wdata;
                CFG_MAX_RANGE:   r_cfg_range <= i_cfg_wdata[9:0];
                default:         ;
            endcase
        end
    end

    localparam int DIST_BITS_W = 10 + FRAC_BITS;
    logic [DIST_BITS_W-1:0] maxd;
    assign maxd = {r_cfg_range, {FRAC_BITS{1'b0}}};

    // Map write: classify the raw value.
    logic occ;
    logic in_map;
    always_comb begin
        occ    = !((i_req.cell_value inside {[0:89]}) || (i_req.cell_value == -8'sd1));
        in_map = (32'(i_req.cell_index) < 32'(MAP_CELLS));
    end

    // Obstacle map, written by the clearing pass or by map writes.
    logic          ram_we, ram_wd, ram_rd;
    logic [AW-1:0] ram_wa;
    logic          ram_q;
    always_comb begin
        if (r_clr_busy) begin
            ram_we = 1'b1;
            ram_wa = r_clr_addr;
            ram_wd = 1'b0;
        end else begin
            ram_we = acc_wr && in_map;
            ram_wa = AW'(i_req.cell_index);
            ram_wd = occ;
        end
        ram_rd = (r_state == S_READ);
    end

    grc_ram #(.WIDTH(1), .DEPTH(MAP_CELLS)) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wa),
        .i_wr_data (ram_wd),
        .i_rd_en   (ram_rd),
        .i_rd_addr (r_addr),
        .o_rd_data (ram_q)
    );

    // Beam offset angle in degrees, reduced modulo a full turn.
    logic [9:0] t_a, t_b, t_mod;
    always_comb begin
        t_a   = 10'd810 - {1'b0, i_req.beam_index};
        t_b   = (t_a >= 10'(DEG_TURN)) ? (t_a - 10'(DEG_TURN)) : t_a;
        t_mod = (t_b >= 10'(DEG_TURN)) ? (t_b - 10'(DEG_TURN)) : t_b;
    end

    // Beam offset converted to a binary angle by a reciprocal multiplication.
    logic [DEG_NUM_W-1:0]  off_num;
    logic [DEG_PROD_W-1:0] off_prod;
    logic [15:0]           off_q;
    always_comb begin
        off_num  = {r_tdeg, 16'b0} + DEG_NUM_W'(DEG_ROUND);
        off_prod = DEG_PROD_W'(off_num) * DEG_PROD_W'(DEG_RECIP);
        off_q    = off_prod[DEG_RECIP_SH+15:DEG_RECIP_SH];
    end

    // CORDIC magnitudes and major axis selection.
    logic [DIV_DEN_W-1:0] mc, ms, mmaj, mmin;
    logic                 x_major;
    logic [STEPS_W-1:0]   steps_prod;
    always_comb begin
        mc         = mag_clamp(r_cx);
        ms         = mag_clamp(r_cy);
        x_major    = (mc > ms);
        mmaj       = x_major ? mc : ms;
        mmin       = x_major ? ms : mc;
        steps_prod = STEPS_W'(mmaj) * STEPS_W'(r_cfg_range);
    end

    // Slope divider.
    logic                 div_start, div_done;
    logic [DIV_NUM_W-1:0] div_num, div_q;
    logic [DIV_DEN_W-1:0] div_den;
    always_comb begin
        div_start = (r_state == S_PREP);
        div_num   = {mmin, {WALK_FRAC{1'b0}}} + DIV_NUM_W'(mmaj >> 1);
        div_den   = mmaj;
    end

    grc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Ray angle folded into the right half plane.
    logic [15:0]             ang;
    logic signed [ANG_W-1:0] z_raw, z0;
    logic                    flip0;
    always_comb begin
        ang   = r_heading + off_q;
        z_raw = $signed({{2{ang[15]}}, ang, 8'b0});
        z0    = z_raw;
        flip0 = 1'b0;
        if (z_raw > QUARTER_24) begin
            z0    = z_raw - HALF_24;
            flip0 = 1'b1;
        end else if (z_raw < -QUARTER_24) begin
            z0    = z_raw + HALF_24;
            flip0 = 1'b1;
        end
    end

    // One CORDIC rotation.
    logic signed [CORDIC_W-1:0] xs, ys, x_nx, y_nx;
    logic signed [ANG_W-1:0]    z_nx;
    always_comb begin
        xs = shr_trunc(r_cx, r_iter);
        ys = shr_trunc(r_cy, r_iter);
        if (!r_z[ANG_W-1]) begin
            x_nx = r_cx - ys;
            y_nx = r_cy + xs;
            z_nx = r_z - atan_lut(r_iter);
        end else begin
            x_nx = r_cx + ys;
            y_nx = r_cy - xs;
            z_nx = r_z + atan_lut(r_iter);
        end
    end

    // Step vectors from the slope quotient.
    logic signed [POS_W-1:0] unit_p, slope_p, dmaj, dmin_c, dmin_s;
    always_comb begin
        unit_p  = POS_W'(1) <<< WALK_FRAC;
        slope_p = $signed(POS_W'(div_q[WALK_FRAC:0]));
        dmaj    = (r_xmaj ? r_cneg : r_sneg) ? -unit_p : unit_p;
        dmin_c  = r_cneg ? -slope_p : slope_p;
        dmin_s  = r_sneg ? -slope_p : slope_p;
    end

    // Cell under the current point and its bounds.
    logic [IDX_W-1:0]    ix, iy;
    logic [ROW_W-1:0]    addr_full;
    logic                walk_leave;
    always_comb begin
        ix         = r_px[POS_W-2:WALK_FRAC];
        iy         = r_py[POS_W-2:WALK_FRAC];
        addr_full  = ROW_W'(ix) + ROW_W'(iy) * ROW_W'(r_cfg_w);
        walk_leave = r_px[POS_W-1] || r_py[POS_W-1]
                  || (ix >= IDX_W'(r_cfg_w)) || (iy >= IDX_W'(r_cfg_h))
                  || (32'(addr_full) >= 32'(MAP_CELLS));
    end

    // Next point and its offset from the origin.
    logic signed [POS_W-1:0] nx, ny, x0w, y0w;
    always_comb begin
        nx  = r_px + r_dx;
        ny  = r_py + r_dy;
        x0w = $signed(POS_W'({r_x0, {RND_SHIFT{1'b0}}}));
        y0w = $signed(POS_W'({r_y0, {RND_SHIFT{1'b0}}}));
    end

    // Offsets rounded half away from zero to output precision.
    logic [POS_W-1:0] mag_ex, mag_ey, rnd_x, rnd_y;
    always_comb begin
        mag_ex = r_ex[POS_W-1] ? $unsigned(-r_ex) : $unsigned(r_ex);
        mag_ey = r_ey[POS_W-1] ? $unsigned(-r_ey) : $unsigned(r_ey);
        rnd_x  = mag_ex + (POS_W'(1) << (RND_SHIFT - 1));
        rnd_y  = mag_ey + (POS_W'(1) << (RND_SHIFT - 1));
    end

    // Squares and one square root step.
    logic [SQ_A_W-1:0] sq_a;
    logic [SQ_W-1:0]   sq_try;
    logic              sq_ge;
    t_dist             dist_cap;
    always_comb begin
        sq_a     = (r_state == S_SQ1) ? (SQ_A_W'(r_ax) * SQ_A_W'(r_ax))
                                      : (SQ_A_W'(r_ay) * SQ_A_W'(r_ay));
        sq_try   = r_sq_r + r_sq_bit;
        sq_ge    = (r_sum >= sq_try);
        dist_cap = (r_sq_r > SQ_W'(maxd)) ? maxd : r_sq_r[DIST_BITS_W-1:0];
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (acc_cast) n_state = S_ANG;
            S_ANG:   n_state = S_COR;
            S_COR:   if (r_iter == 4'(CORDIC_ITERS - 1)) n_state = S_PREP;
            S_PREP:  n_state = S_SLOPE;
            S_SLOPE: if (div_done) n_state = S_ADDR;
            S_ADDR:  n_state = ((r_left == '0) || walk_leave) ? S_DONE : S_READ;
            S_READ:  n_state = S_CHECK;
            S_CHECK: n_state = ram_q ? S_RND : S_ADDR;
            S_RND:   n_state = S_SQ1;
            S_SQ1:   n_state = S_SQ2;
            S_SQ2:   n_state = S_SQRT;
            S_SQRT:  if (r_sq_bit == '0) n_state = S_DONE;
            S_DONE:  if (!r_out_valid || o_rsp.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers: state, clearing pass, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(MAP_CELLS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (r_state == S_DONE && (!r_out_valid || o_rsp.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Query datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_x0      <= i_req.pose_x;
                r_y0      <= i_req.pose_y;
                r_heading <= i_req.heading;
                r_tdeg    <= t_mod[8:0];
            end
            S_ANG: begin
                r_cx   <= CORDIC_GAIN;
                r_cy   <= '0;
                r_z    <= z0;
                r_flip <= flip0;
                r_iter <= '0;
            end
            S_COR: begin
                r_iter <= r_iter + 1'b1;
                r_z    <= z_nx;
                if (r_iter == 4'(CORDIC_ITERS - 1) && r_flip) begin
                    r_cx <= -x_nx;
                    r_cy <= -y_nx;
                end else begin
                    r_cx <= x_nx;
                    r_cy <= y_nx;
                end
            end
            S_PREP: begin
                r_xmaj <= x_major;
                r_cneg <= r_cx[CORDIC_W-1];
                r_sneg <= r_cy[CORDIC_W-1];
                r_left <= steps_prod[STEPS_W-1:30];
                r_px   <= x0w;
                r_py   <= y0w;
            end
            S_SLOPE: begin
                if (r_xmaj) begin
                    r_dx <= dmaj;
                    r_dy <= dmin_s;
                end else begin
                    r_dy <= dmaj;
                    r_dx <= dmin_c;
                end
            end
            S_ADDR: begin
                r_addr <= addr_full[AW-1:0];
                if (r_left == '0) begin
                    r_res_dist <= maxd;
                    r_res_hit  <= 1'b0;
                    r_res_left <= 1'b0;
                end else if (walk_leave) begin
                    r_res_dist <= maxd;
                    r_res_hit  <= 1'b0;
                    r_res_left <= 1'b1;
                end
            end
            S_CHECK: begin
                if (ram_q) begin
                    r_ex <= nx - x0w;
                    r_ey <= ny - y0w;
                end else begin
                    r_px   <= nx;
                    r_py   <= ny;
                    r_left <= r_left - 1'b1;
                end
            end
            S_RND: begin
                r_ax <= rnd_x[RND_SHIFT+SQ_IN_W-1:RND_SHIFT];
                r_ay <= rnd_y[RND_SHIFT+SQ_IN_W-1:RND_SHIFT];
            end
            S_SQ1: begin
                r_sum <= SQ_W'(sq_a);
            end
            S_SQ2: begin
                r_sum    <= r_sum + SQ_W'(sq_a);
                r_sq_r   <= '0;
                r_sq_bit <= SQ_W'(1) << (SQ_W - 2);
            end
            S_SQRT: begin
                if (r_sq_bit == '0) begin
                    r_res_dist <= dist_cap;
                    r_res_hit  <= 1'b1;
                    r_res_left <= 1'b0;
                end else begin
                    if (sq_ge) begin
                        r_sum  <= r_sum - sq_try;
                        r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
                    end else begin
                        r_sq_r <= r_sq_r >> 1;
                    end
                    r_sq_bit <= r_sq_bit >> 2;
                end
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || o_rsp.ready)) begin
            r_out_dist <= r_res_dist;
            r_out_hit  <= r_res_hit;
            r_out_left <= r_res_left;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.distance = r_out_dist;
    assign o_rsp.hit      = r_out_hit;
    assign o_rsp.left_map = r_out_left;
endmodule

>>> hdl/grc_checker.sv
`timescale 1ns / 1ps
`include "grid_ray_cast_range_macros.svh"

// Port-level checks on the ray caster.
module grc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_command,
    input logic out_valid,
    input logic out_ready,
    input logic out_hit,
    input logic out_left_map
);
    // A stalled result item stays offered.
    `GRC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result item dropped")

    // A ray cannot both hit an obstacle and leave the map.
    `GRC_ASSERT_IMP(a_hit_or_left, out_valid, !(out_hit && out_left_map), "hit and left_map")

    // A query keeps the block busy on the following cycle.
    `GRC_ASSERT_NXT(a_cast_busy, in_valid && in_ready && in_command, !in_ready, "ready after query")
endmodule

bind grid_ray_cast_range grc_checker u_grc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .in_valid     (i_req.valid),
    .in_ready     (i_req.ready),
    .in_command   (i_req.command),
    .out_valid    (o_rsp.valid),
    .out_ready    (o_rsp.ready),
    .out_hit      (o_rsp.hit),
    .out_left_map (o_rsp.left_map)
);
